// ===== rtl/core/smt_pkg.sv =====
`timescale 1ns / 1ps

package smt_pkg;

  // default number of table entries
  localparam int SMT_DEPTH = 64;

  // width of one table entry
  localparam int SMT_VAL_W = 32;

  // operation select carried on in_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } smt_op_t;

  // result status
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } smt_status_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                        ins_en;
    logic                        del_en;
    logic signed [SMT_VAL_W-1:0] value;
  } smt_cmd_t;

  // compare flags a cell reports to its neighbors
  typedef struct packed {
    logic gt;  // cell empty or entry above the operand
    logic eq;  // cell occupied and entry equal to the operand
  } smt_flags_t;

endpackage

// ===== rtl/core/smt_cell.sv =====
`timescale 1ns / 1ps

module smt_cell (
  input  logic                                  clk,
  input  smt_pkg::smt_cmd_t                     cmd,
  input  logic                                  occ,
  input  logic                                  left_gt,
  input  logic signed [smt_pkg::SMT_VAL_W-1:0]  left_entry,
  input  logic                                  right_eq,
  input  logic signed [smt_pkg::SMT_VAL_W-1:0]  right_entry,
  output smt_pkg::smt_flags_t                   flags,
  output logic signed [smt_pkg::SMT_VAL_W-1:0]  entry
);
  import smt_pkg::*;

  logic signed [SMT_VAL_W-1:0] entry_r;
  logic signed [SMT_VAL_W-1:0] entry_nxt;
  logic                        lt;
  logic                        eq;

  // compare the held entry against the broadcast operand
  always_comb begin
    lt       = entry_r < cmd.value;
    eq       = entry_r == cmd.value;
    flags.gt = !occ || !(lt || eq);
    flags.eq = occ && eq;
  end

  // insert: take the operand at the insertion point, shift right above it;
  // delete: shift left from the last equal entry upward
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_en && flags.gt) begin
      entry_nxt = left_gt ? left_entry : cmd.value;
    end else if (cmd.del_en && !lt && !right_eq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== rtl/core/sorted_multiset_table.sv =====
// A result is registered on out_* in the cycle after its transaction is accepted.
// One operation per cycle while out_tready drains the output; every cell compares
// and shifts in the same cycle, and the next operation is accepted while the previous
// result is taken. Reset (rst_n low, synchronous) clears the entry count and the output
// valid; the cell entries are not cleared and are only read below the entry count.
`timescale 1ns / 1ps

module sorted_multiset_table #(
  parameter int DEPTH = smt_pkg::SMT_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [smt_pkg::SMT_VAL_W-1:0]        in_tdata,   // [31:0] value
  input  logic                                 in_tuser,   // [0] func
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [OUT_W-1:0]                     out_tdata   // [1:0] status, then entry_count
);
  import smt_pkg::*;

  logic                        in_acc;
  logic                        is_del;
  logic                        full;
  logic                        found;
  smt_cmd_t                    cmd;
  smt_flags_t                  flags [DEPTH];
  logic signed [SMT_VAL_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]            eq_vec;

  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  smt_status_t                 status_r;
  smt_status_t                 status_nxt;
  logic [CNT_W-1:0]            out_count_r;
  logic [CNT_W-1:0]            out_count_nxt;

  // accept while the output register is empty or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign is_del    = (in_tuser == OP_DELETE);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign found     = |eq_vec;

  // broadcast the command to the chain
  always_comb begin
    cmd.value  = in_tdata;
    cmd.ins_en = in_acc && !is_del && !full;
    cmd.del_en = in_acc && is_del && found;
  end

  // row of cells, each linked to its left and right neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                        left_gt;
    logic signed [SMT_VAL_W-1:0] left_entry;
    logic                        right_eq;
    logic signed [SMT_VAL_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_entry = in_tdata;
    end else begin : g_mid_l
      assign left_gt    = flags[i-1].gt;
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_eq    = 1'b0;
      assign right_entry = entries[i];
    end else begin : g_mid_r
      assign right_eq    = flags[i+1].eq;
      assign right_entry = entries[i+1];
    end

    smt_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (count_r > CNT_W'(i)),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_eq    (right_eq),
      .right_entry (right_entry),
      .flags       (flags[i]),
      .entry       (entries[i])
    );

    assign eq_vec[i] = flags[i].eq;
  end

  // update the count and form the result
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    out_count_nxt = out_count_r;
    if (cmd.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.del_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = count_nxt;
      if (is_del) begin
        status_nxt = found ? ST_DONE : ST_NOT_FOUND;
      end else begin
        status_nxt = full ? ST_FULL : ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_count_r, status_r});

  // count stays within the table
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above table depth");

  // an insert into a table with room grows the count by one
  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_del && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count");

  // an insert into a full table gives full status, and the count does not change
  a_full_status : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_del && full) |=> (status_r == ST_FULL && $stable(count_r)))
    else $error("full insert mishandled");

  // a delete with no matching entry gives not-found, and the count does not change
  a_not_found : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_del && !found) |=> (status_r == ST_NOT_FOUND && $stable(count_r)))
    else $error("missing delete mishandled");

  // reported count always matches the held count when a result is loaded
  a_result_count : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_count_r == count_r))
    else $error("result count differs from held count");

endmodule

// ===== bench/smt_checker.sv =====
`timescale 1ns / 1ps

module smt_checker #(
  parameter int DEPTH = smt_pkg::SMT_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [smt_pkg::SMT_VAL_W-1:0] in_tdata,   // [31:0] value
  input  logic                          in_tuser,   // [0] func
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [OUT_W-1:0]              out_tdata,  // [1:0] status, then entry_count
  output int unsigned                   fail_cnt,
  output int unsigned                   open_cnt
);

  import smt_pkg::*;

  typedef struct packed {
    smt_status_t      status;
    logic [CNT_W-1:0] count;
  } table_result_t;

  // shadow copy of the sorted table
  logic signed [SMT_VAL_W-1:0] entries [DEPTH];
  int held;

  table_result_t expected_q [$];
  int unsigned fails = 0;

  assign fail_cnt = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fails++;
  endtask

  // Apply one operation to the shadow table and return the status and count it yields.
  function automatic table_result_t apply_op(input smt_op_t op,
                                             input logic signed [SMT_VAL_W-1:0] v);
    table_result_t res;
    int pos;
    res.status = ST_DONE;
    pos = 0;
    if (op == OP_INSERT) begin
      if (held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // land after every entry equal to the operand
        while (pos < held && entries[pos] <= v) pos++;
        for (int k = held; k > pos; k--) entries[k] = entries[k - 1];
        entries[pos] = v;
        held++;
      end
    end else begin
      while (pos < held && entries[pos] != v) pos++;
      if (pos >= held) begin
        res.status = ST_NOT_FOUND;
      end else begin
        // close the gap left by the removed entry
        for (int k = pos; k + 1 < held; k++) entries[k] = entries[k + 1];
        held--;
      end
    end
    res.count = CNT_W'(held);
    return res;
  endfunction

  // Retire result transactions first: a result never belongs to an operation of the same edge.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      held = 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, out_tdata=%h", out_tdata));
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[1:0] !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d (count %0d)",
                                      out_tdata[1:0], want.status, want.count));
          if (out_tdata[2 +: CNT_W] !== want.count)
            report_mismatch($sformatf("entry_count %0d, predicted %0d",
                                      out_tdata[2 +: CNT_W], want.count));
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_op(smt_op_t'(in_tuser), in_tdata));
    end
    open_cnt <= expected_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  import smt_pkg::*;

  localparam int DEPTH = SMT_DEPTH;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OUT_W = ((2 + CNT_W + 7) / 8) * 8;

  localparam int PHASE_ITEMS = 475;
  localparam int SEG_ITEMS = 80;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    PH_RX_SLOW,
    PH_TX_SLOW,
    PH_FREE
  } run_phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [SMT_VAL_W-1:0] in_tdata;  // [31:0] value
  logic in_tuser;                  // [0] func
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;     // [1:0] status, then entry_count

  int unsigned fail_cnt;
  int unsigned open_cnt;

  run_phase_t run_phase;
  int rx_idle_pct;
  int tx_idle_pct;

  always #5 clk = ~clk;

  sorted_multiset_table #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  smt_checker #(.DEPTH(DEPTH)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_cnt  (fail_cnt),
    .open_cnt  (open_cnt)
  );

  // Offer one operation, with random idle cycles ahead of it, and hold until accepted.
  task automatic send_op(input smt_op_t op, input logic [SMT_VAL_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= value;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Nearly half from a small pool so duplicates and delete hits are common, some extremes, rest raw.
  function automatic logic [SMT_VAL_W-1:0] pick_value();
    int unsigned r;
    logic [SMT_VAL_W-1:0] v;
    r = $urandom_range(99);
    if (r < 45) begin
      v = int'($urandom_range(6)) - 3;
    end else if (r < 55) begin
      case ($urandom_range(3))
        0:       v = 32'h8000_0000;
        1:       v = 32'h8000_0001;
        2:       v = 32'h7FFF_FFFE;
        default: v = 32'h7FFF_FFFF;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  // Cycle the insert bias per segment so the table fills to the top and drains again.
  task automatic run_random(input int n_items);
    int ins_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % SEG_ITEMS == 0) begin
        case ((i / SEG_ITEMS) % 4)
          0:       ins_pct = 95;
          2:       ins_pct = 10;
          default: ins_pct = 50;
        endcase
      end
      send_op(($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE, pick_value());
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off when the free-running phase starts.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_phase == PH_FREE && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Stimulus and verdict
  initial begin
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_INSERT;
    rst_n       <= 1'b0;
    run_phase   <= PH_RX_SLOW;
    rx_idle_pct <= 70;
    tx_idle_pct = 15;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // delete on an empty table
    send_op(OP_DELETE, 32'h0000_0000);
    // extremes and neighbors around zero
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h8000_0000);
    send_op(OP_INSERT, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h0000_0001);
    // duplicates land after equal entries
    send_op(OP_INSERT, 32'h0000_0000);
    send_op(OP_INSERT, 32'h0000_0000);
    // absent value
    send_op(OP_DELETE, 32'h0000_0005);
    send_op(OP_DELETE, 32'h0000_0000);
    send_op(OP_DELETE, 32'h8000_0000);
    send_op(OP_DELETE, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_INSERT, 32'h7FFF_FFFF);
    send_op(OP_DELETE, 32'h7FFF_FFFF);
    send_op(OP_DELETE, 32'h7FFF_FFFF);
    // duplicates exhausted
    send_op(OP_DELETE, 32'h7FFF_FFFF);
    // alternating bit patterns
    send_op(OP_INSERT, 32'h5555_5555);
    send_op(OP_INSERT, 32'hAAAA_AAAA);
    // drain back to empty
    send_op(OP_DELETE, 32'hFFFF_FFFF);
    send_op(OP_DELETE, 32'h0000_0001);
    send_op(OP_DELETE, 32'h0000_0000);
    send_op(OP_DELETE, 32'h0000_0000);
    send_op(OP_DELETE, 32'h5555_5555);
    send_op(OP_DELETE, 32'hAAAA_AAAA);

    run_random(PHASE_ITEMS);

    tx_idle_pct = 70;
    rx_idle_pct <= 15;
    run_phase   <= PH_TX_SLOW;
    run_random(PHASE_ITEMS);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_phase   <= PH_FREE;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
